// File: hdl/cia_pkg.sv
// Package for the checked 64-bit integer ALU: op and status codes, lane record.
// No dependencies; used by cia_cell and checked_int64_alu.
`default_nettype none
package cia_pkg;
    localparam int XLEN   = 64;
    localparam int NCELLS = XLEN;
    localparam logic [XLEN-1:0] SIGN_BIT = {1'b1, {(XLEN-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_NEG = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OVF   = 3'd1,
        ST_DIV0  = 3'd2,
        ST_MOD0  = 3'd3,
        ST_UNSUP = 3'd4
    } t_status;

    // One request in flight. For multiply, hi:lo is the partial product with the
    // multiplier shifting out of lo; for divide, hi is the partial remainder and
    // lo the dividend / quotient. For the other ops lo carries the final result.
    typedef struct packed {
        logic            valid;
        logic [2:0]      op;
        logic            sgn;
        logic            neg_res;
        logic [2:0]      status;
        logic [XLEN-1:0] ma;
        logic [XLEN-1:0] mb;
        logic [XLEN-1:0] hi;
        logic [XLEN-1:0] lo;
    } t_lane;
endpackage
`default_nettype wire

// File: hdl/checked_int64_alu.sv
// Overflow-checked 64-bit integer ALU: setup stage, chain of step cells, result stage.
// Depends on cia_pkg and cia_cell.
//
// Pipeline: one setup register, 64 step cells and one result register lie between
// the accepting edge and the result strobe on o_valid.
// Throughput: one request per cycle; busy never rises, since each cell holds
// exactly one request and every cell advances on every clock.
// The receiver cannot stall; each result shows for one cycle with o_valid high.
// Reset (synchronous, active low) clears every valid bit; payload is not reset.
`default_nettype none
module checked_int64_alu
    import cia_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [2:0]      i_op,
    input  wire logic            i_is_signed,
    input  wire logic [XLEN-1:0] i_operand_a,
    input  wire logic [XLEN-1:0] i_operand_b,
    output logic                 o_valid,
    output logic [XLEN-1:0]      o_result,
    output logic [2:0]           o_status
);
    // ---------------- setup: operand magnitudes, early status, add/sub/neg ------
    logic            a_neg;
    logic            b_neg;
    logic [XLEN-1:0] mag_a;
    logic [XLEN-1:0] mag_b;
    logic [XLEN-1:0] sum;
    logic [XLEN-1:0] diff;
    logic [XLEN-1:0] negated;
    logic            b_zero;
    t_lane           n_front;
    t_lane           r_front;
    t_lane           chain [NCELLS+1];

    assign a_neg   = i_operand_a[XLEN-1];
    assign b_neg   = i_operand_b[XLEN-1];
    assign negated = ~i_operand_a + {{(XLEN-1){1'b0}}, 1'b1};
    assign mag_a   = (i_is_signed && a_neg) ? negated : i_operand_a;
    assign mag_b   = (i_is_signed && b_neg) ?
                     (~i_operand_b + {{(XLEN-1){1'b0}}, 1'b1}) : i_operand_b;
    assign sum     = i_operand_a + i_operand_b;
    assign diff    = i_operand_a - i_operand_b;
    assign b_zero  = (i_operand_b == '0);
    assign busy    = 1'b0;

    always_comb begin
        n_front.valid   = start;
        n_front.op      = i_op;
        n_front.sgn     = i_is_signed;
        n_front.neg_res = 1'b0;
        n_front.status  = ST_OK;
        n_front.ma      = mag_a;
        n_front.mb      = mag_b;
        n_front.hi      = '0;
        n_front.lo      = '0;
        case (i_op)
            OP_ADD: begin
                n_front.lo = sum;
                if (i_is_signed ? (a_neg == b_neg && sum[XLEN-1] != a_neg)
                                : (sum < i_operand_a)) begin
                    n_front.status = ST_OVF;
                end
            end
            OP_SUB: begin
                n_front.lo = diff;
                if (i_is_signed ? (a_neg != b_neg && diff[XLEN-1] != a_neg)
                                : (i_operand_b > i_operand_a)) begin
                    n_front.status = ST_OVF;
                end
            end
            OP_MUL: begin
                // multiplier goes in lo and shifts out one bit per cell
                n_front.lo      = mag_b;
                n_front.neg_res = i_is_signed && (a_neg != b_neg);
            end
            OP_DIV, OP_MOD: begin
                n_front.lo      = mag_a;
                n_front.neg_res = i_is_signed &&
                                  ((i_op == OP_DIV) ? (a_neg != b_neg) : a_neg);
                if (b_zero) begin
                    n_front.status = (i_op == OP_DIV) ? ST_DIV0 : ST_MOD0;
                end else if (i_is_signed && i_operand_a == SIGN_BIT &&
                             i_operand_b == '1) begin
                    n_front.status = ST_OVF;
                end
            end
            OP_NEG: begin
                n_front.lo = negated;
                if (!i_is_signed) begin
                    n_front.status = ST_UNSUP;
                end else if (i_operand_a == SIGN_BIT) begin
                    n_front.status = ST_OVF;
                end
            end
            default: begin
                n_front.status = ST_UNSUP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else begin
            r_front.valid <= n_front.valid;
        end
        r_front.op      <= n_front.op;
        r_front.sgn     <= n_front.sgn;
        r_front.neg_res <= n_front.neg_res;
        r_front.status  <= n_front.status;
        r_front.ma      <= n_front.ma;
        r_front.mb      <= n_front.mb;
        r_front.hi      <= n_front.hi;
        r_front.lo      <= n_front.lo;
    end

    // ---------------- chain: one multiply or divide bit per cell ----------------
    assign chain[0] = r_front;

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        cia_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (chain[g]),
            .o_lane  (chain[g+1])
        );
    end

    // ---------------- result: range check, sign fix-up, zero on error -----------
    t_lane           tail;
    logic [XLEN-1:0] mag_res;
    logic [XLEN-1:0] signed_res;
    logic [2:0]      n_status;
    logic [XLEN-1:0] n_result;
    logic            r_valid;
    logic [XLEN-1:0] r_result;
    logic [2:0]      r_status;

    assign tail       = chain[NCELLS];
    // modulo takes the remainder from hi, everything else the value in lo
    assign mag_res    = (tail.op == OP_MOD) ? tail.hi : tail.lo;
    assign signed_res = tail.neg_res ? (~mag_res + {{(XLEN-1){1'b0}}, 1'b1}) : mag_res;

    always_comb begin
        n_status = tail.status;
        n_result = signed_res;
        if (tail.status == ST_OK && tail.op == OP_MUL) begin
            if (tail.hi != '0) begin
                n_status = ST_OVF;
            end else if (tail.sgn) begin
                if (tail.neg_res ? (tail.lo > SIGN_BIT) : (tail.lo >= SIGN_BIT)) begin
                    n_status = ST_OVF;
                end
            end
        end
        if (n_status != ST_OK) begin
            n_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= tail.valid;
        end
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_status = r_status;
endmodule
`default_nettype wire

// File: hdl/cia_cell.sv
// One step cell of the ALU chain: one multiply bit or one divide bit per request.
// Depends on cia_pkg.
`default_nettype none
module cia_cell
    import cia_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_lane i_lane,
    output t_lane      o_lane
);
    t_lane           r_lane;
    t_lane           n_lane;
    logic [XLEN:0]   mul_sum;
    logic [XLEN:0]   div_shift;
    logic [XLEN:0]   div_diff;

    always_comb begin
        n_lane    = i_lane;
        mul_sum   = {1'b0, i_lane.hi} + (i_lane.lo[0] ? {1'b0, i_lane.ma} : '0);
        div_shift = {i_lane.hi, i_lane.lo[XLEN-1]};
        div_diff  = div_shift - {1'b0, i_lane.mb};
        if (i_lane.status == ST_OK) begin
            case (i_lane.op)
                OP_MUL: begin
                    n_lane.hi = mul_sum[XLEN:1];
                    n_lane.lo = {mul_sum[0], i_lane.lo[XLEN-1:1]};
                end
                OP_DIV, OP_MOD: begin
                    // restoring step: keep the difference when it did not borrow
                    if (!div_diff[XLEN]) begin
                        n_lane.hi = div_diff[XLEN-1:0];
                    end else begin
                        n_lane.hi = div_shift[XLEN-1:0];
                    end
                    n_lane.lo = {i_lane.lo[XLEN-2:0], ~div_diff[XLEN]};
                end
                default: begin
                    n_lane = i_lane;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= n_lane.valid;
        end
        r_lane.op      <= n_lane.op;
        r_lane.sgn     <= n_lane.sgn;
        r_lane.neg_res <= n_lane.neg_res;
        r_lane.status  <= n_lane.status;
        r_lane.ma      <= n_lane.ma;
        r_lane.mb      <= n_lane.mb;
        r_lane.hi      <= n_lane.hi;
        r_lane.lo      <= n_lane.lo;
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire
